/* sv/tfn_pkg.sv */
package tfn_pkg;

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic degenerate;
    } tfn_ctl_t;

endpackage

/* sv/tfn_in_if.sv */
interface tfn_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

/* sv/tfn_out_if.sv */
interface tfn_out_if #(
    parameter int NORMAL_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic                           degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

/* sv/tfn_front.sv */
module tfn_front
    import tfn_pkg::*;
#(
    parameter int CW = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [CW-1:0]      coord [9],
    output tfn_ctl_t                  ctl,
    output logic                      neg [3],
    output logic [2*(2*CW+1)-1:0]     sq [3],
    output logic [2*(2*CW+1)+1:0]     s
);
    localparam int E   = CW + 1;
    localparam int XW  = 2 * CW + 2;
    localparam int MW  = 2 * CW + 1;
    localparam int LO  = (MW + 1) / 2;
    localparam int HI  = MW - LO;
    localparam int HHW = 2 * HI;
    localparam int HLW = HI + LO;
    localparam int LLW = 2 * LO;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;

    logic [5:0]           v_reg;
    logic signed [E-1:0]  e_reg [6];
    logic signed [XW-1:0] p_reg [6];
    logic signed [XW-1:0] c_reg [3];
    logic [MW-1:0]        mag_reg [3];
    logic                 neg4_reg [3];
    logic                 neg5_reg [3];
    logic                 neg6_reg [3];
    logic                 neg7_reg [3];
    logic [HHW-1:0]       hh_reg [3];
    logic [HLW-1:0]       hl_reg [3];
    logic [LLW-1:0]       ll_reg [3];
    logic [SQW-1:0]       sq6_reg [3];
    logic [SQW-1:0]       sq7_reg [3];
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        s_next;
    tfn_ctl_t             ctl_reg;

    // valid bits of the first six stages and the control of the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v_reg              <= {v_reg[4:0], in_valid};
            ctl_reg.valid      <= v_reg[5];
            ctl_reg.degenerate <= (s_next == '0);
        end
    end

    // squared length of the cross product
    assign s_next = SW'(sq6_reg[0]) + SW'(sq6_reg[1]) + SW'(sq6_reg[2]);

    // edges, cross products, magnitudes, partial squares and their sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= E'(coord[0]) - E'(coord[3]);
            e_reg[1] <= E'(coord[1]) - E'(coord[4]);
            e_reg[2] <= E'(coord[2]) - E'(coord[5]);
            e_reg[3] <= E'(coord[3]) - E'(coord[6]);
            e_reg[4] <= E'(coord[4]) - E'(coord[7]);
            e_reg[5] <= E'(coord[5]) - E'(coord[8]);

            p_reg[0] <= XW'(e_reg[1]) * XW'(e_reg[5]);
            p_reg[1] <= XW'(e_reg[2]) * XW'(e_reg[4]);
            p_reg[2] <= XW'(e_reg[2]) * XW'(e_reg[3]);
            p_reg[3] <= XW'(e_reg[0]) * XW'(e_reg[5]);
            p_reg[4] <= XW'(e_reg[0]) * XW'(e_reg[4]);
            p_reg[5] <= XW'(e_reg[1]) * XW'(e_reg[3]);

            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]    <= p_reg[2*i] - p_reg[2*i+1];
                mag_reg[i]  <= c_reg[i][XW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
                neg4_reg[i] <= c_reg[i][XW-1];
                hh_reg[i]   <= HHW'(mag_reg[i][MW-1:LO]) * HHW'(mag_reg[i][MW-1:LO]);
                hl_reg[i]   <= HLW'(mag_reg[i][MW-1:LO]) * HLW'(mag_reg[i][LO-1:0]);
                ll_reg[i]   <= LLW'(mag_reg[i][LO-1:0]) * LLW'(mag_reg[i][LO-1:0]);
                neg5_reg[i] <= neg4_reg[i];
                sq6_reg[i]  <= (SQW'(hh_reg[i]) << (2 * LO))
                             + (SQW'(hl_reg[i]) << (LO + 1))
                             + SQW'(ll_reg[i]);
                neg6_reg[i] <= neg5_reg[i];
                sq7_reg[i]  <= sq6_reg[i];
                neg7_reg[i] <= neg6_reg[i];
            end
            s_reg <= s_next;
        end
    end

    assign ctl = ctl_reg;
    assign s   = s_reg;
    assign neg = neg7_reg;
    assign sq  = sq7_reg;

endmodule

/* sv/tfn_lane.sv */
module tfn_lane
    import tfn_pkg::*;
#(
    parameter int MW = 49,
    parameter int F  = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  tfn_ctl_t          ctl_in,
    input  logic              neg_in,
    input  logic [2*MW-1:0]   sq,
    input  logic [2*MW+1:0]   s,
    output tfn_ctl_t          ctl_out,
    output logic              neg_out,
    output logic [F:0]        q
);
    localparam int N   = F + 2;
    localparam int RSW = 2 * MW + 2 * F + 8;

    // residual is c^2 * 2^(2F+2) - t^2 * s, with t = 2q - 1
    logic signed [RSW-1:0] r_reg  [N];
    logic signed [RSW-1:0] st_reg [N];
    logic [RSW-1:0]        s_reg  [N];
    logic [F:0]            q_reg  [N];
    logic                  neg_reg [N];
    tfn_ctl_t              ctl_reg [N];

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k < N; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // start with q = 0, t = -1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= $signed({6'b0, sq, {(2*F+2){1'b0}}})
                        - $signed({{(2*F+6){1'b0}}, s});
            st_reg[0]  <= -$signed({{(2*F+6){1'b0}}, s});
            s_reg[0]   <= {{(2*F+6){1'b0}}, s};
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_in;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j < N; j++)
    begin : g_digit
        localparam int B = F + 1 - j;
        logic signed [RSW-1:0] rc;
        logic                  take;

        assign rc = r_reg[j-1] - (st_reg[j-1] <<< (B + 2))
                  - $signed(s_reg[j-1] << (2 * B + 2));
        assign take = !rc[RSW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= take ? rc : r_reg[j-1];
                st_reg[j]  <= take ? st_reg[j-1] + $signed(s_reg[j-1] << (B + 1))
                                   : st_reg[j-1];
                q_reg[j]   <= take ? (q_reg[j-1] | ((F+1)'(1) << B)) : q_reg[j-1];
                s_reg[j]   <= s_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign ctl_out = ctl_reg[N-1];
    assign neg_out = neg_reg[N-1];
    assign q       = q_reg[N-1];

endmodule

/* sv/triangle_face_normal.sv */
// Unit face normal of a triangle. Each accepted word carries three vertices;
// the block forms the edges first-second and second-third, their exact cross
// product, and divides each component by the length of that product with a
// bit-exact digit recurrence that needs no divider or root unit. Components
// come out as signed Q1.(NORMAL_WIDTH-1), rounded half away from zero,
// positive full scale saturated; a triangle with zero-length cross product
// sets degenerate and returns zeros. One triangle is taken every cycle; the
// pipeline has seven stages for edges, cross product and squared length,
// one stage per quotient bit plus one setup stage in each of three parallel
// component lanes, and the output register. The whole pipeline holds while
// a finished word waits on the result side.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tfn_in_if.sink    triangle,
    tfn_out_if.source result
);
    localparam int MW = 2 * COORD_WIDTH + 1;
    localparam int F  = NORMAL_WIDTH - 1;

    logic                         en;
    logic signed [COORD_WIDTH-1:0] coord [9];
    tfn_ctl_t                     front_ctl;
    logic                         front_neg [3];
    logic [2*MW-1:0]              front_sq [3];
    logic [2*MW+1:0]              front_s;
    tfn_ctl_t                     lane_ctl;
    logic                         lane_neg [3];
    logic [F:0]                   lane_q [3];
    logic                         valid_reg;
    logic signed [F:0]            nx_reg;
    logic signed [F:0]            ny_reg;
    logic signed [F:0]            nz_reg;
    logic                         deg_reg;

    // sign, saturation and degenerate override of one component
    function automatic logic [F:0] finish(input logic [F:0] qv, input logic ng,
                                          input logic dg);
        logic [F:0] res;
        if (dg)
            res = '0;
        else if (ng)
            res = ~qv + (F+1)'(1);
        else if (qv[F])
            res = {1'b0, {F{1'b1}}};
        else
            res = qv;
        return res;
    endfunction

    // pipeline advances unless a result word is stuck
    assign en             = !valid_reg || result.ready;
    assign triangle.ready = en;

    assign coord[0] = triangle.first_x;
    assign coord[1] = triangle.first_y;
    assign coord[2] = triangle.first_z;
    assign coord[3] = triangle.second_x;
    assign coord[4] = triangle.second_y;
    assign coord[5] = triangle.second_z;
    assign coord[6] = triangle.third_x;
    assign coord[7] = triangle.third_y;
    assign coord[8] = triangle.third_z;

    tfn_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (triangle.valid),
        .coord    (coord),
        .ctl      (front_ctl),
        .neg      (front_neg),
        .sq       (front_sq),
        .s        (front_s)
    );

    // lane x carries the control for the word
    tfn_lane #(
        .MW (MW),
        .F  (F)
    ) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .neg_in  (front_neg[0]),
        .sq      (front_sq[0]),
        .s       (front_s),
        .ctl_out (lane_ctl),
        .neg_out (lane_neg[0]),
        .q       (lane_q[0])
    );

    tfn_lane #(
        .MW (MW),
        .F  (F)
    ) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .neg_in  (front_neg[1]),
        .sq      (front_sq[1]),
        .s       (front_s),
        .ctl_out (),
        .neg_out (lane_neg[1]),
        .q       (lane_q[1])
    );

    tfn_lane #(
        .MW (MW),
        .F  (F)
    ) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .neg_in  (front_neg[2]),
        .sq      (front_sq[2]),
        .s       (front_s),
        .ctl_out (),
        .neg_out (lane_neg[2]),
        .q       (lane_q[2])
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= lane_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= finish(lane_q[0], lane_neg[0], lane_ctl.degenerate);
            ny_reg  <= finish(lane_q[1], lane_neg[1], lane_ctl.degenerate);
            nz_reg  <= finish(lane_q[2], lane_neg[2], lane_ctl.degenerate);
            deg_reg <= lane_ctl.degenerate;
        end
    end

    assign result.valid      = valid_reg;
    assign result.normal_x   = nx_reg;
    assign result.normal_y   = ny_reg;
    assign result.normal_z   = nz_reg;
    assign result.degenerate = deg_reg;

endmodule

/* tb/tb_triangle_face_normal.sv */
`timescale 1ns / 1ps

module tb_triangle_face_normal;

    localparam int CW = 24;
    localparam int NW = 16;
    localparam int FRAC = NW - 1;
    localparam int LATENCY = NW + 9;
    localparam int NUM_RANDOM = 1000;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [CW-1:0] v [9];
    } triangle_t;

    typedef struct {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic                 degenerate;
    } normal_t;

    // scoreboard: predicts the unit normal of each accepted triangle
    class normal_scoreboard;
        normal_t pending[$];
        int      errors;
        int      checked;
        int      degenerate_seen;

        // rounded, saturated component for cross component c, squared length s
        function automatic logic signed [NW-1:0] unit_component(
            logic signed [63:0] c, logic [127:0] s);
            logic [63:0]  mag;
            logic [255:0] rhs;
            logic [255:0] lhs;
            logic [63:0]  q;
            logic [63:0]  cand;
            logic [63:0]  odd;
            mag = c[63] ? -c : c;
            rhs = (256'(mag) * 256'(mag)) << (2 * FRAC + 2);
            q = 0;
            for (int b = FRAC; b >= 0; b--)
            begin
                cand = q | (64'd1 << b);
                odd = 2 * cand - 1;
                lhs = 256'(odd) * 256'(odd) * 256'(s);
                if (lhs <= rhs)
                    q = cand;
            end
            if (!c[63] && q > (64'd1 << FRAC) - 1)
                q = (64'd1 << FRAC) - 1;
            if (c[63])
                q = -q;
            return q[NW-1:0];
        endfunction

        function void note_triangle(triangle_t t);
            logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
            logic [127:0] len_sq;
            normal_t e;
            ax = 64'(t.v[0]) - 64'(t.v[3]);
            ay = 64'(t.v[1]) - 64'(t.v[4]);
            az = 64'(t.v[2]) - 64'(t.v[5]);
            bx = 64'(t.v[3]) - 64'(t.v[6]);
            by = 64'(t.v[4]) - 64'(t.v[7]);
            bz = 64'(t.v[5]) - 64'(t.v[8]);
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            len_sq = 128'($signed(cx) * 128'sd1) * 128'($signed(cx) * 128'sd1)
                   + 128'($signed(cy) * 128'sd1) * 128'($signed(cy) * 128'sd1)
                   + 128'($signed(cz) * 128'sd1) * 128'($signed(cz) * 128'sd1);
            if (len_sq == 0)
            begin
                e = '{0, 0, 0, 1'b1};
            end
            else
            begin
                e.nx = unit_component(cx, len_sq);
                e.ny = unit_component(cy, len_sq);
                e.nz = unit_component(cz, len_sq);
                e.degenerate = 1'b0;
            end
            pending.push_back(e);
        endfunction

        task check_normal(normal_t got);
            normal_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.degenerate)
                degenerate_seen++;
            if (got.nx !== e.nx)
                report_mismatch($sformatf("normal_x got %0d want %0d", got.nx, e.nx));
            if (got.ny !== e.ny)
                report_mismatch($sformatf("normal_y got %0d want %0d", got.ny, e.ny));
            if (got.nz !== e.nz)
                report_mismatch($sformatf("normal_z got %0d want %0d", got.nz, e.nz));
            if (got.degenerate !== e.degenerate)
                report_mismatch($sformatf("degenerate got %0b want %0b",
                    got.degenerate, e.degenerate));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at word %0d: %s", checked, msg);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tfn_in_if  #(.COORD_WIDTH(CW))  triangle_ch();
    tfn_out_if #(.NORMAL_WIDTH(NW)) result_ch();

    triangle_face_normal #(
        .COORD_WIDTH (CW),
        .NORMAL_WIDTH(NW)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .triangle(triangle_ch.sink),
        .result  (result_ch.source)
    );

    normal_scoreboard board = new();
    triangle_t stim[$];
    bit  sending_done = 1'b0;
    bit  hold_off_done = 1'b0;
    int  idle_cycles = 0;
    int  accepted = 0;

    always #2 clk = ~clk;

    initial
    begin
        triangle_ch.valid = 1'b0;
        for (int i = 0; i < 9; i++)
            drive_coord(i, '0);
        result_ch.ready = 1'b0;
    end

    task automatic drive_coord(int i, logic signed [CW-1:0] val);
        case (i)
            0: triangle_ch.first_x  <= val;
            1: triangle_ch.first_y  <= val;
            2: triangle_ch.first_z  <= val;
            3: triangle_ch.second_x <= val;
            4: triangle_ch.second_y <= val;
            5: triangle_ch.second_z <= val;
            6: triangle_ch.third_x  <= val;
            7: triangle_ch.third_y  <= val;
            default: triangle_ch.third_z <= val;
        endcase
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            1: return CW'($signed($urandom_range(0, 40)) - 20);
            2: return CW'($signed($urandom_range(0, 4000)) - 2000);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic triangle_t make_triangle(int kind);
        triangle_t t;
        logic signed [CW-1:0] base;
        for (int i = 0; i < 9; i++)
            t.v[i] = rand_coord();
        case (kind)
            // collinear or coincident vertices
            0: begin
                for (int i = 0; i < 3; i++)
                    t.v[3 + i] = t.v[i];
            end
            1: begin
                for (int i = 0; i < 3; i++)
                begin
                    base = CW'($signed($urandom_range(0, 200)) - 100);
                    t.v[i] = base;
                    t.v[3 + i] = CW'(base * 2);
                    t.v[6 + i] = CW'(base * 3);
                end
            end
            // triangle in an axis plane, normal along an axis
            2: begin
                base = rand_coord();
                t.v[$urandom_range(0, 2) * 1 + 0] = t.v[0];
                for (int i = 0; i < 3; i++)
                    t.v[3 * i + 2] = base;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic triangle_t tri_of(int v0, int v1, int v2, int v3, int v4,
                                         int v5, int v6, int v7, int v8);
        triangle_t t;
        t.v = '{CW'(v0), CW'(v1), CW'(v2), CW'(v3), CW'(v4), CW'(v5),
                CW'(v6), CW'(v7), CW'(v8)};
        return t;
    endfunction

    // directed corner cases, then random words
    initial
    begin
        triangle_t t;
        int mx;
        int mn;
        mx = (1 << (CW - 1)) - 1;
        mn = -(1 << (CW - 1));
        stim.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        stim.push_back(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0));
        stim.push_back(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0));
        stim.push_back(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0));
        stim.push_back(tri_of(0, 0, 0, 256, 0, 0, 0, 0, 256));
        stim.push_back(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256));
        stim.push_back(tri_of(0, 0, 0, 0, 0, 256, 0, 256, 0));
        stim.push_back(tri_of(1, 2, 3, 2, 4, 6, 3, 6, 9));
        stim.push_back(tri_of(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        stim.push_back(tri_of(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        stim.push_back(tri_of(mx, 0, 0, mn, 0, 0, 0, mx, 0));
        stim.push_back(tri_of(mn, mx, 0, mx, mn, mn, 0, 0, mx));
        stim.push_back(tri_of(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        stim.push_back(tri_of(-1, -1, -1, 0, 0, 0, 1, 0, -1));
        stim.push_back(tri_of(1, 0, 0, 0, 1, 0, 0, 0, 1));
        stim.push_back(tri_of(mn, mn, 0, mx, mn, 0, mx, mx, 0));
        stim.push_back(tri_of(mn, 0, mn, mx, 0, mn, mx, 0, mx));
        stim.push_back(tri_of(3, 1, 0, 0, 0, 0, 1, 3, 0));
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            t = make_triangle($urandom_range(0, 9));
            stim.push_back(t);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_triangles();
    end

    task automatic send_triangles();
        int gap;
        @(posedge clk);
        gap = 0;
        foreach (stim[k])
        begin
            repeat (gap) @(posedge clk);
            triangle_ch.valid <= 1'b1;
            for (int i = 0; i < 9; i++)
                drive_coord(i, stim[k].v[i]);
            @(posedge clk);
            while (!triangle_ch.ready)
                @(posedge clk);
            board.note_triangle(stim[k]);
            accepted++;
            // keep valid high when the next word goes out with no gap
            gap = (((k + 1) % 200) < 40) ? 0 : $urandom_range(0, 10);
            if (k == stim.size() - 1 || gap > 0)
                triangle_ch.valid <= 1'b0;
        end
        sending_done = 1'b1;
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        int wait_cycles;
        normal_t got;
        @(posedge rst_n);
        forever
        begin
            if (!hold_off_done && accepted > 100)
            begin
                hold_off_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (4 * LATENCY) @(posedge clk);
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if ((accepted % 300) < 60)
                wait_cycles = 0;
            if (wait_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got.nx = result_ch.normal_x;
            got.ny = result_ch.normal_y;
            got.nz = result_ch.normal_z;
            got.degenerate = result_ch.degenerate;
            board.check_normal(got);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((triangle_ch.valid && triangle_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("watchdog: no progress, %0d results outstanding", board.pending.size());
            $display("tb_triangle_face_normal: FAIL");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        $display("covered %0d triangles, %0d degenerate, with input and output stalls",
            board.checked, board.degenerate_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_triangle_face_normal: PASS");
        else
            $display("tb_triangle_face_normal: FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/tfn_pkg.sv
sv/tfn_in_if.sv
sv/tfn_out_if.sv
sv/tfn_front.sv
sv/tfn_lane.sv
sv/triangle_face_normal.sv
tb/tb_triangle_face_normal.sv
